// File: hdl/q24a_pkg.sv
// Q24.8 fixed-point ALU package: opcodes, default widths and side-band record.
// Used by the channel interfaces and by q24_8_fixed_point_alu.
`timescale 1ns / 1ps
package q24a_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned OP_W           = 4;
  localparam int unsigned FRAC_BITS_DFLT = 8;

  localparam logic [OP_W-1:0] OP_ADD = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV = 4'd3;
  localparam logic [OP_W-1:0] OP_MIN = 4'd4;
  localparam logic [OP_W-1:0] OP_MAX = 4'd5;
  localparam logic [OP_W-1:0] OP_INC = 4'd6;
  localparam logic [OP_W-1:0] OP_DEC = 4'd7;
  localparam logic [OP_W-1:0] OP_I2F = 4'd8;
  localparam logic [OP_W-1:0] OP_F2I = 4'd9;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              is_div;
    logic              neg;
    logic              dz;
    logic              eq;
    logic              lt;
    logic              gt;
  } side_t;

endpackage

// File: hdl/q24a_chan_if.sv
// Request and response channel interfaces of the Q24.8 ALU.
// Depends on q24a_pkg.
`timescale 1ns / 1ps
interface q24a_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [q24a_pkg::OP_W-1:0]     req_type;
  logic signed [q24a_pkg::DATA_W-1:0]   operand_a;
  logic signed [q24a_pkg::DATA_W-1:0]   operand_b;
  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface q24a_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [q24a_pkg::DATA_W-1:0]   result;
  logic                                 div_by_zero;
  logic                                 a_equals_b;
  logic                                 a_less_b;
  logic                                 a_greater_b;
  modport source (output valid, result, div_by_zero, a_equals_b, a_less_b, a_greater_b,
                  input ready);
  modport sink   (input valid, result, div_by_zero, a_equals_b, a_less_b, a_greater_b,
                  output ready);
endinterface

// File: hdl/q24_8_fixed_point_alu.sv
// Q24.8 fixed-point ALU top level: input register, multiply stage, pipelined divider.
// Depends on q24a_pkg and the q24a_req_if / q24a_rsp_if interfaces.
//
// Takes one item per cycle and returns one result per item, in order. The pipeline is
// an input register, one stage holding the 32x32 multiply and the simple operations,
// one restoring-divide stage per quotient bit (32 + FRAC_BITS of them), and the output
// register. The whole pipeline stalls together while the output register holds an item
// that is not taken.
`timescale 1ns / 1ps
module q24_8_fixed_point_alu #(
  parameter int unsigned FRAC_BITS = q24a_pkg::FRAC_BITS_DFLT
) (
  input  logic            clk,
  input  logic            rst_n,
  q24a_req_if.sink        in_ch,
  q24a_rsp_if.source      out_ch
);

  localparam int unsigned DW = q24a_pkg::DATA_W;
  localparam int unsigned QW = DW + FRAC_BITS;

  logic en;

  logic                          s1_vld_r;
  logic [q24a_pkg::OP_W-1:0]     s1_op_r;
  logic signed [DW-1:0]          s1_a_r;
  logic signed [DW-1:0]          s1_b_r;

  logic                          dv_vld_r  [0:QW];
  logic [QW-1:0]                 dv_num_r  [0:QW];
  logic [DW-1:0]                 dv_rem_r  [0:QW];
  logic [DW-1:0]                 dv_dm_r   [0:QW];
  q24a_pkg::side_t               dv_side_r [0:QW];

  logic                          out_vld_r;
  logic [DW-1:0]                 out_res_r;
  logic                          out_dz_r;
  logic                          out_eq_r;
  logic                          out_lt_r;
  logic                          out_gt_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_ch.valid;
    end
    if (en) begin
      s1_op_r <= in_ch.req_type;
      s1_a_r  <= in_ch.operand_a;
      s1_b_r  <= in_ch.operand_b;
    end
  end

  logic signed [2*DW-1:0] prod;
  logic signed [DW:0]     f2i_sum;
  logic signed [DW:0]     f2i_sh;
  logic [DW-1:0]          mag_a;
  logic [DW-1:0]          mag_b;
  q24a_pkg::side_t        side_nxt;

  always_comb begin
    prod    = s1_a_r * s1_b_r;
    f2i_sum = {s1_a_r[DW-1], s1_a_r}
            + (s1_a_r[DW-1] ? (DW+1)'((64'd1 << FRAC_BITS) - 64'd1) : '0);
    f2i_sh  = f2i_sum >>> FRAC_BITS;
    mag_a   = s1_a_r[DW-1] ? DW'(-s1_a_r) : DW'(s1_a_r);
    mag_b   = s1_b_r[DW-1] ? DW'(-s1_b_r) : DW'(s1_b_r);
    side_nxt        = '0;
    side_nxt.eq     = (s1_a_r == s1_b_r);
    side_nxt.lt     = (s1_a_r < s1_b_r);
    side_nxt.gt     = (s1_a_r > s1_b_r);
    side_nxt.dz     = (s1_op_r == q24a_pkg::OP_DIV) && (s1_b_r == '0);
    side_nxt.is_div = (s1_op_r == q24a_pkg::OP_DIV) && (s1_b_r != '0);
    side_nxt.neg    = s1_a_r[DW-1] ^ s1_b_r[DW-1];
    case (s1_op_r)
      q24a_pkg::OP_ADD: side_nxt.res = DW'(s1_a_r + s1_b_r);
      q24a_pkg::OP_SUB: side_nxt.res = DW'(s1_a_r - s1_b_r);
      q24a_pkg::OP_MUL: side_nxt.res = prod[FRAC_BITS +: DW];
      q24a_pkg::OP_MIN: side_nxt.res = (s1_a_r <= s1_b_r) ? s1_a_r : s1_b_r;
      q24a_pkg::OP_MAX: side_nxt.res = (s1_b_r > s1_a_r) ? s1_b_r : s1_a_r;
      q24a_pkg::OP_INC: side_nxt.res = DW'(s1_a_r + 1);
      q24a_pkg::OP_DEC: side_nxt.res = DW'(s1_a_r - 1);
      q24a_pkg::OP_I2F: side_nxt.res = DW'(s1_a_r <<< FRAC_BITS);
      q24a_pkg::OP_F2I: side_nxt.res = f2i_sh[DW-1:0];
      default:          side_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= s1_vld_r;
    end
    if (en) begin
      dv_num_r[0]  <= {mag_a, FRAC_BITS'(0)};
      dv_rem_r[0]  <= '0;
      dv_dm_r[0]   <= mag_b;
      dv_side_r[0] <= side_nxt;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [DW:0] rem_sh;
    logic [DW:0] diff;
    assign rem_sh = {dv_rem_r[k-1], dv_num_r[k-1][QW-1]};
    assign diff   = rem_sh - {1'b0, dv_dm_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else if (en) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
      if (en) begin
        dv_num_r[k]  <= {dv_num_r[k-1][QW-2:0], !diff[DW]};
        dv_rem_r[k]  <= diff[DW] ? rem_sh[DW-1:0] : diff[DW-1:0];
        dv_dm_r[k]   <= dv_dm_r[k-1];
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  logic [QW-1:0] quo_fix;
  assign quo_fix = dv_side_r[QW].neg ? QW'(-dv_num_r[QW]) : dv_num_r[QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld_r[QW];
    end
    if (en) begin
      out_res_r <= dv_side_r[QW].is_div ? quo_fix[DW-1:0] : dv_side_r[QW].res;
      out_dz_r  <= dv_side_r[QW].dz;
      out_eq_r  <= dv_side_r[QW].eq;
      out_lt_r  <= dv_side_r[QW].lt;
      out_gt_r  <= dv_side_r[QW].gt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.result      = out_res_r;
  assign out_ch.div_by_zero = out_dz_r;
  assign out_ch.a_equals_b  = out_eq_r;
  assign out_ch.a_less_b    = out_lt_r;
  assign out_ch.a_greater_b = out_gt_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_dz_r |-> out_res_r == '0)
    else $error("divide by zero with nonzero result");

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> $onehot({out_eq_r, out_lt_r, out_gt_r}))
    else $error("comparison flags not one-hot");

  a_in_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && en |=> s1_vld_r)
    else $error("accepted item dropped at input stage");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en && dv_vld_r[QW] |=> dv_vld_r[QW])
    else $error("divider output lost during stall");

endmodule

// File: verif/q24a_tb_chan_if.sv
// Testbench package of the Q24.8 ALU: the expected-result record used by the checker.
// Depends on q24a_pkg.
`timescale 1ns / 1ps
package q24a_tb_pkg;

  typedef struct packed {
    logic signed [q24a_pkg::DATA_W-1:0] result;
    logic                               dz;
    logic                               eq;
    logic                               lt;
    logic                               gt;
  } alu_res_t;
endpackage

// File: verif/q24a_alu_checker.sv
// Checker for the Q24.8 ALU: watches both channels, computes each expected result
// and compares the results in order. Depends on q24a_pkg, q24a_tb_pkg and the interfaces.
`timescale 1ns / 1ps
module q24a_alu_checker (
  input  logic   clk,
  input  logic   rst_n,
  q24a_req_if    req,
  q24a_rsp_if    rsp,
  output int     n_fail,
  output int     n_pending,
  output int     n_results
);

  localparam int FB = q24a_pkg::FRAC_BITS_DFLT;

  q24a_tb_pkg::alu_res_t exp_q[$];

  function automatic q24a_tb_pkg::alu_res_t alu_predict(logic [q24a_pkg::OP_W-1:0] op,
                                                        logic signed [31:0] a,
                                                        logic signed [31:0] b);
    q24a_tb_pkg::alu_res_t r;
    logic signed [63:0] wide;
    logic signed [63:0] num;
    r.result = '0;
    r.dz = 1'b0;
    r.eq = (a == b);
    r.lt = (a < b);
    r.gt = (a > b);
    case (op)
      q24a_pkg::OP_ADD: r.result = a + b;
      q24a_pkg::OP_SUB: r.result = a - b;
      q24a_pkg::OP_MUL: begin
        wide = 64'(a) * 64'(b);
        wide = wide >>> FB;
        r.result = wide[31:0];
      end
      q24a_pkg::OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = 64'(a) <<< FB;
          wide = num / 64'(b);
          r.result = wide[31:0];
        end
      end
      q24a_pkg::OP_MIN: r.result = (a <= b) ? a : b;
      q24a_pkg::OP_MAX: r.result = (b > a) ? b : a;
      q24a_pkg::OP_INC: r.result = a + 32'sd1;
      q24a_pkg::OP_DEC: r.result = a - 32'sd1;
      q24a_pkg::OP_I2F: r.result = a <<< FB;
      q24a_pkg::OP_F2I: begin
        wide = 64'(a) / (64'sd1 <<< FB);
        r.result = wide[31:0];
      end
      default: r.result = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    q24a_tb_pkg::alu_res_t e;
    q24a_tb_pkg::alu_res_t got;
    if (rst_n && req.valid && req.ready)
      exp_q.push_back(alu_predict(req.req_type, req.operand_a, req.operand_b));
    if (rst_n && rsp.valid && rsp.ready) begin
      got = '{rsp.result, rsp.div_by_zero, rsp.a_equals_b, rsp.a_less_b, rsp.a_greater_b};
      n_results++;
      if (exp_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("ERROR: unexpected result %h", got);
      end else begin
        e = exp_q.pop_front();
        if (got !== e) begin
          n_fail++;
          if (n_fail <= 10)
            $display("ERROR: result %0d exp res=%h dz=%b eq=%b lt=%b gt=%b,",
                     n_results, e.result, e.dz, e.eq, e.lt, e.gt,
                     " got res=%h dz=%b eq=%b lt=%b gt=%b",
                     got.result, got.dz, got.eq, got.lt, got.gt);
        end
      end
    end
    n_pending = exp_q.size();
  end
endmodule

// File: verif/testbench.sv
// Top of the Q24.8 ALU testbench: clock, reset, request and response traffic, verdict.
// Depends on q24a_pkg, the channel interfaces, q24a_alu_checker and q24_8_fixed_point_alu.
`timescale 1ns / 1ps
module testbench;

  localparam int N_RAND  = 1630;
  localparam int LATENCY = 42;

  localparam logic [q24a_pkg::OP_W-1:0] OP_RSV_LO = 4'd10;
  localparam logic [q24a_pkg::OP_W-1:0] OP_RSV_HI = 4'd15;

  logic clk;
  logic rst_n;
  int   n_fail;
  int   n_pending;
  int   n_results;
  int   n_sent;
  bit   send_done;
  bit   hold_rsp;
  bit   in_hold;

  q24a_req_if req ();
  q24a_rsp_if rsp ();

  q24_8_fixed_point_alu u_top (.clk(clk), .rst_n(rst_n), .in_ch(req), .out_ch(rsp));

  q24a_alu_checker u_chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                          .n_fail(n_fail), .n_pending(n_pending), .n_results(n_results));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 4)) - 32'd2;
      3: return 32'($urandom_range(0, 2047)) - 32'd1024;
      4: return 32'($urandom_range(0, 32'h3ffff)) - 32'h1ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(logic [q24a_pkg::OP_W-1:0] op, logic [31:0] a, logic [31:0] b);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (in_hold) gap = 0;
    repeat (gap) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.req_type  <= op;
    req.operand_a <= a;
    req.operand_b <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  initial begin
    logic [q24a_pkg::OP_W-1:0] ops[10];
    ops = '{q24a_pkg::OP_ADD, q24a_pkg::OP_SUB, q24a_pkg::OP_MUL, q24a_pkg::OP_DIV,
            q24a_pkg::OP_MIN, q24a_pkg::OP_MAX, q24a_pkg::OP_INC, q24a_pkg::OP_DEC,
            q24a_pkg::OP_I2F, q24a_pkg::OP_F2I};
    req.valid = 1'b0;
    req.req_type = '0;
    req.operand_a = '0;
    req.operand_b = '0;
    n_sent = 0;
    send_done = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (ops[i]) send_item(ops[i], 32'h0000_0300, 32'hffff_fe80);
    send_item(q24a_pkg::OP_DIV, 32'h0000_0100, 32'h0);
    send_item(q24a_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_item(q24a_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_item(q24a_pkg::OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
    send_item(q24a_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001);
    send_item(q24a_pkg::OP_INC, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(q24a_pkg::OP_DEC, 32'h8000_0000, 32'h8000_0000);
    send_item(q24a_pkg::OP_F2I, 32'hffff_ff01, 32'h0);
    send_item(q24a_pkg::OP_F2I, 32'h8000_0000, 32'h0);
    send_item(q24a_pkg::OP_I2F, 32'hffff_ffff, 32'h1);
    send_item(q24a_pkg::OP_MIN, 32'h5, 32'h5);
    send_item(q24a_pkg::OP_MAX, 32'hffff_fffb, 32'h5);
    send_item(OP_RSV_LO, 32'h1, 32'h2);
    send_item(OP_RSV_HI, 32'hffff_ffff, 32'h0);
    for (int i = 0; i < N_RAND; i++) begin
      logic [q24a_pkg::OP_W-1:0] op;
      logic [31:0] b;
      op = $urandom_range(0, 9) == 0 ? 4'($urandom_range(OP_RSV_LO, OP_RSV_HI))
                                     : ops[$urandom_range(0, 9)];
      b = $urandom_range(0, 9) == 0 ? pick_operand() & 32'h0 : pick_operand();
      if ($urandom_range(0, 15) == 0) b = '0;
      send_item(op, pick_operand(), b);
    end
    req.valid <= 1'b0;
    send_done = 1'b1;
  end

  initial begin
    rsp.ready = 1'b0;
    hold_rsp = 1'b0;
    in_hold = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      int gap;
      if (n_sent >= 300 && !hold_rsp) begin
        hold_rsp = 1'b1;
        in_hold = 1'b1;
        rsp.ready <= 1'b0;
        repeat (150) @(negedge clk);
        in_hold = 1'b0;
      end
      gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 18) : 0;
      if (n_sent > 1000 && n_sent < 1200) gap = 0;
      repeat (gap) begin
        rsp.ready <= 1'b0;
        @(negedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    wait (send_done);
    while (n_pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Run covered %0d items over all ten operations and unused codes,", n_sent);
    $display("with a long output stall that filled the pipeline; %0d results checked.",
             n_results);
    if (n_fail == 0 && n_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end
endmodule
